FILE: rtl/core/ptt_pkg.sv
package ptt_pkg;

  // Request codes carried in req_type
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_MIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_MAX   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_TICKS = 3'd7;

  // Field widths
  localparam int GAIN_W  = 16;
  localparam int ANGLE_W = 8;
  localparam int PULSE_W = 12;

  // Reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd19661;
  localparam int                 CENTER_X_RST   = 320;
  localparam int                 CENTER_Y_RST   = 240;
  localparam logic [ANGLE_W-1:0] PAN_MIN_RST    = 8'd10;
  localparam logic [ANGLE_W-1:0] PAN_MAX_RST    = 8'd170;
  localparam logic [ANGLE_W-1:0] TILT_MIN_RST   = 8'd20;
  localparam logic [ANGLE_W-1:0] TILT_MAX_RST   = 8'd150;
  localparam logic [ANGLE_W-1:0] BEEP_TICKS_RST = 8'd80;

  // Angles and pulse widths
  localparam logic [ANGLE_W-1:0] ANGLE_MID  = 8'd90;
  localparam logic [ANGLE_W-1:0] ANGLE_FULL = 8'd180;
  localparam logic [PULSE_W-1:0] PULSE_MIN  = 12'd500;
  // ceil(2^16 / 9): exact floor of x/9 for x up to 18000
  localparam logic [27:0]        RECIP_9    = 28'd7282;

  // 500 + floor(2000 * a / 180) = 500 + floor(100 * a / 9)
  function automatic logic [PULSE_W-1:0] pulse_of(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] ac;
    logic [14:0]        x;
    logic [27:0]        q;
    ac = (a > ANGLE_FULL) ? ANGLE_FULL : a;
    x  = 15'(ac) * 15'd100;
    q  = 28'(x) * RECIP_9;
    return PULSE_MIN + PULSE_W'(q[27:16]);
  endfunction

endpackage

FILE: rtl/core/ptt_if.sv
// Input channel: one sample or one tick per transfer
interface ptt_in_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [COORD_BITS-1:0] target_x;
  logic [COORD_BITS-1:0] target_y;
  logic                  detected;

  modport source (output valid, req_type, target_x, target_y, detected, input ready);
  modport sink   (input valid, req_type, target_x, target_y, detected, output ready);
endinterface

// Result channel: servo angles, pulse widths, laser and buzzer drive
interface ptt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pan_deg;
  logic [7:0]  tilt_deg;
  logic [11:0] pan_pulse_us;
  logic [11:0] tilt_pulse_us;
  logic        laser_on;
  logic        buzzer_on;

  modport source (output valid, pan_deg, tilt_deg, pan_pulse_us, tilt_pulse_us,
                  laser_on, buzzer_on, input ready);
  modport sink   (input valid, pan_deg, tilt_deg, pan_pulse_us, tilt_pulse_us,
                  laser_on, buzzer_on, output ready);
endinterface

FILE: rtl/core/pan_tilt_target_tracker_core.sv
// Channel  | Direction | Payload                                          | Handshake
// in_chan  | in        | req_type, target_x, target_y, detected           | valid/ready
// out_chan | out       | pan_deg, tilt_deg, pan/tilt_pulse_us, laser, buzz | valid/ready
// cfg_*    | in        | cfg_idx, cfg_data                                | cfg_we only
//
// A sample with a target passes through S_PAN, S_TILT, S_CLAMP and S_OUT
// between two transfers: the pan and tilt offsets pass one after the other
// through the shared multiplier, then the tilt clamp, then the result
// register load, then S_IDLE with ready high. Ticks and samples without a
// target go from S_IDLE to S_OUT. The result register stalls the loop only
// when a previous result has not been taken. Reset is synchronous, active low.
module pan_tilt_target_tracker_core import ptt_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ptt_in_if.sink                in_chan,
  ptt_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = COORD_BITS + 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAN,
    S_TILT,
    S_CLAMP,
    S_OUT
  } state_t;

  state_t                   state_r;

  // configuration
  logic [GAIN_W-1:0]        gain_r;
  logic [COORD_BITS-1:0]    center_x_r;
  logic [COORD_BITS-1:0]    center_y_r;
  logic [ANGLE_W-1:0]       pan_min_r;
  logic [ANGLE_W-1:0]       pan_max_r;
  logic [ANGLE_W-1:0]       tilt_min_r;
  logic [ANGLE_W-1:0]       tilt_max_r;
  logic [ANGLE_W-1:0]       beep_ticks_r;

  // tracker state
  logic [ANGLE_W-1:0]       pan_hold_r;
  logic [ANGLE_W-1:0]       tilt_hold_r;
  logic                     was_detected_r;
  logic                     laser_r;
  logic                     beep_active_r;
  logic [ANGLE_W-1:0]       beep_left_r;

  // latched coordinates
  logic [COORD_BITS-1:0]    tx_r;
  logic [COORD_BITS-1:0]    ty_r;

  // result register
  logic                     out_valid_r;
  logic [ANGLE_W-1:0]       out_pan_r;
  logic [ANGLE_W-1:0]       out_tilt_r;
  logic [PULSE_W-1:0]       out_pan_pulse_r;
  logic [PULSE_W-1:0]       out_tilt_pulse_r;
  logic                     out_laser_r;
  logic                     out_buzzer_r;

  logic                     in_xfer;
  logic                     is_tick;
  logic                     det;
  logic                     beep_active_nxt;
  logic [ANGLE_W-1:0]       beep_left_nxt;
  logic [COORD_BITS-1:0]    op_pos;
  logic [COORD_BITS-1:0]    op_centre;
  logic signed [COORD_BITS:0] p_r;
  logic signed [AW-1:0]     p_ext;
  logic [ANGLE_W-1:0]       pan_lim;
  logic [ANGLE_W-1:0]       tilt_lim;

  // low limit, then high limit, then the servo range 0..180
  function automatic logic [ANGLE_W-1:0] limit_angle(input logic signed [AW-1:0] a,
                                                     input logic [ANGLE_W-1:0] lo,
                                                     input logic [ANGLE_W-1:0] hi);
    logic signed [AW-1:0] v;
    v = a;
    if (v < signed'(AW'(lo))) v = signed'(AW'(lo));
    if (v > signed'(AW'(hi))) v = signed'(AW'(hi));
    if (v < signed'(AW'(0))) v = signed'(AW'(0));
    if (v > signed'(AW'(ANGLE_FULL))) v = signed'(AW'(ANGLE_FULL));
    return v[ANGLE_W-1:0];
  endfunction

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign is_tick       = (in_chan.req_type == REQ_TICK);
  assign det           = in_chan.detected;

  // beep bookkeeping for the item being transferred
  always_comb begin
    beep_active_nxt = beep_active_r;
    beep_left_nxt   = beep_left_r;
    if (is_tick) begin
      if (beep_active_r && (beep_left_r != '0)) begin
        beep_left_nxt = beep_left_r - 8'd1;
      end
    end else if (det && !was_detected_r) begin
      beep_active_nxt = 1'b1;
      beep_left_nxt   = beep_ticks_r;
    end
    if (beep_active_nxt && (beep_left_nxt == '0)) begin
      beep_active_nxt = 1'b0;
    end
  end

  // shared multiplier: pan operands in S_PAN, tilt operands otherwise
  assign op_pos    = (state_r == S_PAN) ? tx_r : ty_r;
  assign op_centre = (state_r == S_PAN) ? center_x_r : center_y_r;

  ptt_offset_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_offset (
    .clk    (clk),
    .pos    (op_pos),
    .centre (op_centre),
    .gain   (gain_r),
    .p_r    (p_r)
  );

  assign p_ext    = AW'(p_r);
  assign pan_lim  = limit_angle(signed'(AW'(ANGLE_MID)) - p_ext, pan_min_r, pan_max_r);
  assign tilt_lim = limit_angle(signed'(AW'(ANGLE_MID)) + p_ext, tilt_min_r, tilt_max_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r       <= GAIN_RST;
      center_x_r   <= COORD_BITS'(CENTER_X_RST);
      center_y_r   <= COORD_BITS'(CENTER_Y_RST);
      pan_min_r    <= PAN_MIN_RST;
      pan_max_r    <= PAN_MAX_RST;
      tilt_min_r   <= TILT_MIN_RST;
      tilt_max_r   <= TILT_MAX_RST;
      beep_ticks_r <= BEEP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GAIN:       gain_r       <= cfg_data;
        REG_CENTER_X:   center_x_r   <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Y:   center_y_r   <= cfg_data[COORD_BITS-1:0];
        REG_PAN_MIN:    pan_min_r    <= cfg_data[ANGLE_W-1:0];
        REG_PAN_MAX:    pan_max_r    <= cfg_data[ANGLE_W-1:0];
        REG_TILT_MIN:   tilt_min_r   <= cfg_data[ANGLE_W-1:0];
        REG_TILT_MAX:   tilt_max_r   <= cfg_data[ANGLE_W-1:0];
        REG_BEEP_TICKS: beep_ticks_r <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // coordinates captured at transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tx_r <= in_chan.target_x;
      ty_r <= in_chan.target_y;
    end
  end

  // result payload, loaded when the result register is free
  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && (!out_valid_r || out_chan.ready)) begin
      out_pan_r        <= pan_hold_r;
      out_tilt_r       <= tilt_hold_r;
      out_pan_pulse_r  <= pulse_of(pan_hold_r);
      out_tilt_pulse_r <= pulse_of(tilt_hold_r);
      out_laser_r      <= laser_r;
      out_buzzer_r     <= beep_active_r;
    end
  end

  // sequencer, tracker state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pan_hold_r     <= ANGLE_MID;
      tilt_hold_r    <= ANGLE_MID;
      was_detected_r <= 1'b0;
      laser_r        <= 1'b0;
      beep_active_r  <= 1'b0;
      beep_left_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // S_OUT reloads the result register itself when it is taken
      if (out_valid_r && out_chan.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            beep_active_r <= beep_active_nxt;
            beep_left_r   <= beep_left_nxt;
            if (!is_tick) begin
              laser_r        <= det;
              was_detected_r <= det;
            end
            state_r <= (!is_tick && det) ? S_PAN : S_OUT;
          end
        end
        S_PAN: begin
          state_r <= S_TILT;
        end
        S_TILT: begin
          pan_hold_r <= pan_lim;
          state_r    <= S_CLAMP;
        end
        S_CLAMP: begin
          tilt_hold_r <= tilt_lim;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pan_deg       = out_pan_r;
  assign out_chan.tilt_deg      = out_tilt_r;
  assign out_chan.pan_pulse_us  = out_pan_pulse_r;
  assign out_chan.tilt_pulse_us = out_tilt_pulse_r;
  assign out_chan.laser_on      = out_laser_r;
  assign out_chan.buzzer_on     = out_buzzer_r;

endmodule

FILE: rtl/core/ptt_offset_unit.sv
// Shared proportional unit: sign(e) * floor(gain * |e| / 2^16), registered
module ptt_offset_unit import ptt_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic [COORD_BITS-1:0]        pos,
  input  logic [COORD_BITS-1:0]        centre,
  input  logic [GAIN_W-1:0]            gain,
  output logic signed [COORD_BITS:0]   p_r
);

  localparam int PROD_W = GAIN_W + COORD_BITS;

  logic signed [COORD_BITS:0]   err;
  logic                         neg;
  logic signed [COORD_BITS:0]   err_abs;
  logic [COORD_BITS-1:0]        mag;
  logic [PROD_W-1:0]            prod;
  logic [COORD_BITS-1:0]        prod_hi;
  logic signed [COORD_BITS:0]   p_nxt;

  // offset from centre, magnitude, product, restore sign
  always_comb begin
    err     = signed'({1'b0, pos}) - signed'({1'b0, centre});
    neg     = err[COORD_BITS];
    err_abs = neg ? -err : err;
    mag     = err_abs[COORD_BITS-1:0];
    prod    = PROD_W'(gain) * PROD_W'(mag);
    prod_hi = prod[PROD_W-1:GAIN_W];
    p_nxt   = neg ? -signed'({1'b0, prod_hi}) : signed'({1'b0, prod_hi});
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

FILE: tb/sv/pan_tilt_target_tracker_core_tb.sv
module pan_tilt_target_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam int COORD_BITS   = 10;
  localparam int COORD_MASK   = (1 << COORD_BITS) - 1;
  localparam int PULSE_SPAN   = 2000;
  localparam int RUN_LIMIT_NS = 10_000_000;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One result as it leaves the block
  typedef struct packed {
    logic [ANGLE_W-1:0] pan;
    logic [ANGLE_W-1:0] tilt;
    logic [PULSE_W-1:0] pan_us;
    logic [PULSE_W-1:0] tilt_us;
    logic               laser;
    logic               buzz;
  } servo_res_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ptt_in_if #(.COORD_BITS(COORD_BITS)) in_chan ();
  ptt_out_if                           out_chan ();

  pan_tilt_target_tracker_core #(.COORD_BITS(COORD_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Tracker configuration mirror
  logic [GAIN_W-1:0] trk_gain;
  int trk_cx, trk_cy;
  int trk_pan_lo, trk_pan_hi, trk_tilt_lo, trk_tilt_hi;
  int trk_beep_len;

  // Tracker state mirror
  int   pan_hold, tilt_hold;
  logic seen_target, laser_lit, beeping;
  int   beep_count;

  servo_res_t pending_results[$];
  int         mismatches;
  bit         bursts_on;
  int         hold_off_left;

  always #5 clk = ~clk;

  // sign(e) * floor(gain * |e| / 2^16)
  function automatic int gain_offset(int pos, int ctr);
    int     e;
    longint mag;
    int     p;
    e   = pos - ctr;
    mag = (e < 0) ? -e : e;
    p   = int'((longint'(trk_gain) * mag) >> 16);
    return (e < 0) ? -p : p;
  endfunction

  // low limit first, then high limit, then the servo range
  function automatic int clamp_angle(int a, int lo, int hi);
    if (a < lo) a = lo;
    if (a > hi) a = hi;
    if (a < 0) a = 0;
    if (a > int'(ANGLE_FULL)) a = int'(ANGLE_FULL);
    return a;
  endfunction

  function automatic int servo_pulse_us(int a);
    return int'(PULSE_MIN) + (PULSE_SPAN * a) / int'(ANGLE_FULL);
  endfunction

  // Advance the tracker by one transfer and return the result it produces
  function automatic servo_res_t advance_tracker(logic kind, coord_t x, coord_t y, logic det);
    servo_res_t r;
    if (kind == REQ_TICK) begin
      if (beeping && beep_count > 0) beep_count--;
    end else begin
      if (det) begin
        laser_lit = 1'b1;
        if (!seen_target) begin
          beeping    = 1'b1;
          beep_count = trk_beep_len;
        end
        pan_hold  = clamp_angle(int'(ANGLE_MID) - gain_offset(int'(x), trk_cx),
                                trk_pan_lo, trk_pan_hi);
        tilt_hold = clamp_angle(int'(ANGLE_MID) + gain_offset(int'(y), trk_cy),
                                trk_tilt_lo, trk_tilt_hi);
      end else begin
        laser_lit = 1'b0;
      end
      seen_target = det;
    end
    if (beeping && beep_count == 0) beeping = 1'b0;
    r.pan     = ANGLE_W'(pan_hold);
    r.tilt    = ANGLE_W'(tilt_hold);
    r.pan_us  = PULSE_W'(servo_pulse_us(pan_hold));
    r.tilt_us = PULSE_W'(servo_pulse_us(tilt_hold));
    r.laser   = laser_lit;
    r.buzz    = beeping;
    return r;
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) note_mismatch(what, want, got);
  endfunction

  // Result checker: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    servo_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with none pending", 0, 1);
      end else begin
        want = pending_results.pop_front();
        check_field("pan_deg", want.pan, out_chan.pan_deg);
        check_field("tilt_deg", want.tilt, out_chan.tilt_deg);
        check_field("pan_pulse_us", want.pan_us, out_chan.pan_pulse_us);
        check_field("tilt_pulse_us", want.tilt_us, out_chan.tilt_pulse_us);
        check_field("laser_on", want.laser, out_chan.laser_on);
        check_field("buzzer_on", want.buzz, out_chan.buzzer_on);
      end
    end
  end

  // Result side: long hold-off on request, otherwise random stall bursts while bursts are on
  initial begin
    int burst_left;
    out_chan.ready = 1'b0;
    burst_left     = 0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_off_left--;
      end else if (burst_left > 0) begin
        out_chan.ready <= 1'b0;
        burst_left--;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
        out_chan.ready <= 1'b0;
        burst_left = $urandom_range(1, 19) - 1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Offer one item, wait for its transfer, then queue its expected result
  task automatic send_item(logic kind, coord_t x, coord_t y, logic det);
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= kind;
    in_chan.target_x <= x;
    in_chan.target_y <= y;
    in_chan.detected <= det;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.push_back(advance_tracker(kind, x, y, det));
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, coord_t'($urandom), coord_t'($urandom), 1'($urandom));
  endtask

  // Stop offering and wait until every result has been taken
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN:       trk_gain     = d;
      REG_CENTER_X:   trk_cx       = int'(d) & COORD_MASK;
      REG_CENTER_Y:   trk_cy       = int'(d) & COORD_MASK;
      REG_PAN_MIN:    trk_pan_lo   = int'(d[7:0]);
      REG_PAN_MAX:    trk_pan_hi   = int'(d[7:0]);
      REG_TILT_MIN:   trk_tilt_lo  = int'(d[7:0]);
      REG_TILT_MAX:   trk_tilt_hi  = int'(d[7:0]);
      REG_BEEP_TICKS: trk_beep_len = int'(d[7:0]);
      default: ;
    endcase
  endtask

  function automatic int random_limit();
    if ($urandom_range(0, 7) == 0) return $urandom_range(181, 255);
    return $urandom_range(0, 180);
  endfunction

  // New settings for a random phase: random values, full-range centres, extremes now and then
  task automatic random_config();
    int lo, hi;
    case ($urandom_range(0, 4))
      0:       write_reg(REG_GAIN, 0);
      1:       write_reg(REG_GAIN, 16'hFFFF);
      2:       write_reg(REG_GAIN, $urandom_range(0, 8192));
      default: write_reg(REG_GAIN, $urandom_range(0, 65535));
    endcase
    write_reg(REG_CENTER_X, $urandom_range(0, 65535));
    write_reg(REG_CENTER_Y, $urandom_range(0, 65535));
    lo = random_limit();
    hi = random_limit();
    // mostly ordered limits, sometimes inverted
    if (lo > hi && $urandom_range(0, 3) != 0) begin
      write_reg(REG_PAN_MIN, hi);
      write_reg(REG_PAN_MAX, lo);
    end else begin
      write_reg(REG_PAN_MIN, lo);
      write_reg(REG_PAN_MAX, hi);
    end
    lo = random_limit();
    hi = random_limit();
    if (lo > hi && $urandom_range(0, 3) != 0) begin
      write_reg(REG_TILT_MIN, hi);
      write_reg(REG_TILT_MAX, lo);
    end else begin
      write_reg(REG_TILT_MIN, lo);
      write_reg(REG_TILT_MAX, hi);
    end
    case ($urandom_range(0, 7))
      0:       write_reg(REG_BEEP_TICKS, 0);
      1:       write_reg(REG_BEEP_TICKS, 255);
      2:       write_reg(REG_BEEP_TICKS, $urandom_range(0, 255) | 16'hFF00);
      default: write_reg(REG_BEEP_TICKS, $urandom_range(1, 12));
    endcase
  endtask

  // Reset settings: centre, corners, lost target, ticks
  task automatic test_reset_state();
    send_tick();
    send_item(REQ_SAMPLE, 0, 0, 1'b0);
    send_item(REQ_SAMPLE, 320, 240, 1'b1);
    send_item(REQ_SAMPLE, 0, 0, 1'b1);
    send_item(REQ_SAMPLE, 1023, 1023, 1'b1);
    send_tick();
    send_item(REQ_SAMPLE, 512, 512, 1'b0);
    drain_results();
  endtask

  // Beep length, beep end, restart during a beep, zero-length beep
  task automatic test_beep_timing();
    write_reg(REG_BEEP_TICKS, 3);
    send_item(REQ_SAMPLE, 300, 200, 1'b1);
    send_tick();
    send_item(REQ_SAMPLE, 330, 260, 1'b1);
    send_tick();
    send_tick();
    send_item(REQ_SAMPLE, 330, 260, 1'b0);
    send_item(REQ_SAMPLE, 310, 250, 1'b1);
    send_item(REQ_SAMPLE, 310, 250, 1'b0);
    send_item(REQ_SAMPLE, 320, 240, 1'b1);
    drain_results();
    write_reg(REG_BEEP_TICKS, 0);
    send_item(REQ_SAMPLE, 0, 0, 1'b0);
    send_item(REQ_SAMPLE, 640, 480, 1'b1);
    send_tick();
    drain_results();
  endtask

  // Full gain, zero gain, inverted limits, limits past 180, wide centre writes
  task automatic test_angle_limits();
    write_reg(REG_GAIN, 16'hFFFF);
    write_reg(REG_CENTER_X, 16'hFC00);
    write_reg(REG_CENTER_Y, 16'hFFFF);
    write_reg(REG_PAN_MIN, 100);
    write_reg(REG_PAN_MAX, 50);
    write_reg(REG_TILT_MIN, 200);
    write_reg(REG_TILT_MAX, 255);
    send_item(REQ_SAMPLE, 1023, 0, 1'b1);
    send_item(REQ_SAMPLE, 0, 1023, 1'b1);
    drain_results();
    write_reg(REG_GAIN, 0);
    write_reg(REG_PAN_MIN, 0);
    write_reg(REG_PAN_MAX, 255);
    write_reg(REG_TILT_MIN, 0);
    write_reg(REG_TILT_MAX, 0);
    send_item(REQ_SAMPLE, 1023, 1023, 1'b1);
    send_item(REQ_SAMPLE, 0, 0, 1'b1);
    drain_results();
  endtask

  // Target tracks with drifting positions and ticks, plus some raw noise
  task automatic test_random_tracking(int n_items);
    int sent;
    int px, py;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(1'($urandom), coord_t'($urandom), coord_t'($urandom), 1'($urandom));
        sent++;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          px = $urandom_range(0, COORD_MASK);
          py = $urandom_range(0, COORD_MASK);
        end else begin
          px = (trk_cx + $urandom_range(0, 400) - 200) & COORD_MASK;
          py = (trk_cy + $urandom_range(0, 400) - 200) & COORD_MASK;
        end
        repeat ($urandom_range(2, 12)) begin
          send_item(REQ_SAMPLE, coord_t'(px), coord_t'(py), 1'b1);
          sent++;
          repeat ($urandom_range(0, 3)) begin
            send_tick();
            sent++;
          end
          px = (px + $urandom_range(0, 40) - 20) & COORD_MASK;
          py = (py + $urandom_range(0, 40) - 20) & COORD_MASK;
        end
        // target lost, then ticks so that a beep can run out
        repeat ($urandom_range(1, 3)) begin
          send_item(REQ_SAMPLE, coord_t'($urandom), coord_t'($urandom), 1'b0);
          sent++;
        end
        repeat ($urandom_range(0, 12)) begin
          send_tick();
          sent++;
        end
      end
    end
    drain_results();
  endtask

  // Result side holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    bursts_on     = 1'b0;
    hold_off_left = 200;
    repeat (12) begin
      send_item(REQ_SAMPLE, coord_t'($urandom), coord_t'($urandom), 1'($urandom));
      send_tick();
    end
    drain_results();
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_GAIN;
    cfg_data         = '0;
    in_chan.valid    = 1'b0;
    in_chan.req_type = REQ_SAMPLE;
    in_chan.target_x = '0;
    in_chan.target_y = '0;
    in_chan.detected = 1'b0;
    mismatches       = 0;
    bursts_on        = 1'b0;
    hold_off_left    = 0;

    trk_gain     = GAIN_RST;
    trk_cx       = CENTER_X_RST;
    trk_cy       = CENTER_Y_RST;
    trk_pan_lo   = int'(PAN_MIN_RST);
    trk_pan_hi   = int'(PAN_MAX_RST);
    trk_tilt_lo  = int'(TILT_MIN_RST);
    trk_tilt_hi  = int'(TILT_MAX_RST);
    trk_beep_len = int'(BEEP_TICKS_RST);
    pan_hold     = int'(ANGLE_MID);
    tilt_hold    = int'(ANGLE_MID);
    seen_target  = 1'b0;
    laser_lit    = 1'b0;
    beeping      = 1'b0;
    beep_count   = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_beep_timing();
    test_angle_limits();
    bursts_on = 1'b1;
    repeat (5) begin
      random_config();
      test_random_tracking(330);
    end
    test_backpressure();
    // closing stretch at full rate
    bursts_on = 1'b0;
    random_config();
    test_random_tracking(300);

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("pan_tilt_target_tracker_core_tb OK");
    end else begin
      $display("pan_tilt_target_tracker_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("pan_tilt_target_tracker_core_tb NOT OK");
    $finish;
  end

endmodule
